>>> hdl/obar_pkg.sv
// ----------------------------------------------------------------------------
// obar_pkg
// Shared types and constants for the OHLCV bar aggregator.
// ----------------------------------------------------------------------------
`default_nettype none

package obar_pkg;

    localparam int NUM_SYMBOLS = 32;
    localparam int SLOT_W      = $clog2(NUM_SYMBOLS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int PRICE_W     = 32;
    localparam int TIME_W      = 32;
    localparam int VOL_IN_W    = 32;
    localparam int VOL_W       = 48;

    localparam logic [TIME_W-1:0] LEN_MIN1 = 32'd60;
    localparam logic [TIME_W-1:0] LEN_MIN5 = 32'd300;
    localparam logic [TIME_W-1:0] LEN_DAY  = 32'd86400;

    // floor(2^32 / length) for the reciprocal divide
    localparam logic [31:0] RECIP_MIN1 = 32'((64'd1 << 32) / 64'd60);
    localparam logic [31:0] RECIP_MIN5 = 32'((64'd1 << 32) / 64'd300);
    localparam logic [31:0] RECIP_DAY  = 32'((64'd1 << 32) / 64'd86400);

    localparam logic [1:0] PERIOD_MIN1 = 2'd0;
    localparam logic [1:0] PERIOD_MIN5 = 2'd1;
    localparam logic [1:0] PERIOD_DAY  = 2'd2;
    localparam logic [1:0] PERIOD_RAW  = 2'd3;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SNAP = 1'b1;

    localparam logic [1:0] KIND_LIVE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    localparam logic CFG_PERIOD  = 1'b0;
    localparam logic CFG_SYMBOLS = 1'b1;

    typedef struct packed {
        logic [1:0]       period;
        logic [CNT_W-1:0] tracked;
    } t_cfg;

    typedef struct packed {
        logic                op;
        logic [4:0]          symbol;
        logic [TIME_W-1:0]   tick_time;
        logic [PRICE_W-1:0]  price;
        logic [VOL_IN_W-1:0] volume;
    } t_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         symbol;
        logic [TIME_W-1:0]  bar_time;
        logic [PRICE_W-1:0] open;
        logic [PRICE_W-1:0] high;
        logic [PRICE_W-1:0] low;
        logic [PRICE_W-1:0] close;
        logic [VOL_W-1:0]   volume;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_T_MUL,
        S_T_ALIGN,
        S_T_UPD,
        S_S_MIN,
        S_S_CHECK,
        S_S_WALK,
        S_S_END
    } t_state;

endpackage

`default_nettype wire

>>> hdl/obar_front.sv
// ----------------------------------------------------------------------------
// obar_front
// Input acceptance, classification and a two-entry queue to the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module obar_front import obar_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    output logic       o_q_valid,
    output t_item      o_q_item,
    input  wire logic  i_q_pop
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       accept;
    logic       drop;
    logic       push;

    assign o_ready   = (r_count != 2'd2);
    assign accept    = i_valid && o_ready;
    // ticks for slots beyond the tracked count change nothing
    assign drop      = (i_item.op == OP_TICK) && ({1'b0, i_item.symbol} >= i_cfg.tracked);
    assign push      = accept && !drop;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

`default_nettype wire

>>> hdl/obar_engine.sv
// ----------------------------------------------------------------------------
// obar_engine
// Per-symbol bar tables, tick update sequence, snapshot walk, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module obar_engine import obar_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_q_valid,
    input  wire t_item i_q_item,
    output logic       o_q_pop,
    output logic       o_out_valid,
    output t_result    o_out,
    input  wire logic  i_out_ready
);

    logic [TIME_W-1:0]  live_start [NUM_SYMBOLS];
    logic [TIME_W-1:0]  live_end   [NUM_SYMBOLS];
    logic [PRICE_W-1:0] live_open  [NUM_SYMBOLS];
    logic [PRICE_W-1:0] live_high  [NUM_SYMBOLS];
    logic [PRICE_W-1:0] live_low   [NUM_SYMBOLS];
    logic [PRICE_W-1:0] live_close [NUM_SYMBOLS];
    logic [VOL_W-1:0]   live_vol   [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] r_has;
    logic [NUM_SYMBOLS-1:0] r_done_valid;
    logic [PRICE_W-1:0] done_open  [NUM_SYMBOLS];
    logic [PRICE_W-1:0] done_high  [NUM_SYMBOLS];
    logic [PRICE_W-1:0] done_low   [NUM_SYMBOLS];
    logic [PRICE_W-1:0] done_close [NUM_SYMBOLS];
    logic [VOL_W-1:0]   done_vol   [NUM_SYMBOLS];

    t_state r_state, n_state;
    t_item  r_item;
    logic [63:0]        r_prod;
    logic [TIME_W-1:0]  r_qp;
    logic [TIME_W-1:0]  r_start;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [TIME_W-1:0]  r_min, n_min;
    logic [TIME_W-1:0]  r_prior, n_prior;
    logic               r_taken, n_taken;
    logic               r_pend_valid, n_pend_valid;
    t_result            r_pend, n_pend;
    logic               r_out_valid;
    t_result            r_out;

    logic [TIME_W-1:0]  per_len;
    logic [31:0]        recip;
    logic [SLOT_W-1:0]  addr;
    logic               out_free;
    logic               out_wr;
    t_result            out_data;
    logic               save_en;
    logic               tick_wr;
    logic [TIME_W-1:0]  rem0, rem1;
    logic               rolled, had;
    logic [TIME_W:0]    end_sum;
    logic [VOL_W:0]     vol_sum;
    logic [VOL_W-1:0]   vol_base;
    logic               started, aligned, entry;
    t_result            new_entry;
    t_result            none_res;

    always_comb begin
        case (i_cfg.period)
            PERIOD_MIN5: begin per_len = LEN_MIN5; recip = RECIP_MIN5; end
            PERIOD_DAY:  begin per_len = LEN_DAY;  recip = RECIP_DAY;  end
            default:     begin per_len = LEN_MIN1; recip = RECIP_MIN1; end
        endcase
    end

    assign addr     = (r_state == S_T_UPD) ? r_item.symbol : r_idx[SLOT_W-1:0];
    assign out_free = !r_out_valid || i_out_ready;

    // remainder estimate is below twice the length, one correction
    assign rem0 = r_item.tick_time - r_qp;
    assign rem1 = (rem0 >= per_len) ? rem0 - per_len : rem0;

    assign rolled   = r_start >= live_end[addr];
    assign had      = !rolled && r_has[addr];
    assign end_sum  = {1'b0, r_start} + {1'b0, per_len};
    assign vol_base = rolled ? '0 : live_vol[addr];
    assign vol_sum  = {1'b0, vol_base} + (VOL_W+1)'(r_item.volume);

    assign started = r_has[addr] || (live_start[addr] != '0);
    assign aligned = r_has[addr] && (live_start[addr] == r_min);
    assign entry   = aligned || r_done_valid[addr];

    always_comb begin
        new_entry.kind     = aligned ? KIND_LIVE : KIND_DONE;
        new_entry.symbol   = 5'(addr);
        new_entry.bar_time = r_min;
        new_entry.open     = aligned ? live_open[addr]  : done_open[addr];
        new_entry.high     = aligned ? live_high[addr]  : done_high[addr];
        new_entry.low      = aligned ? live_low[addr]   : done_low[addr];
        new_entry.close    = aligned ? live_close[addr] : done_close[addr];
        new_entry.volume   = aligned ? live_vol[addr]   : done_vol[addr];
        new_entry.last     = 1'b0;
        none_res           = '0;
        none_res.kind      = KIND_NONE;
        none_res.last      = 1'b1;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_min        = r_min;
        n_prior      = r_prior;
        n_taken      = r_taken;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        o_q_pop      = 1'b0;
        out_wr       = 1'b0;
        out_data     = r_pend;
        save_en      = 1'b0;
        tick_wr      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_idx   = '0;
                    n_min   = '0;
                    n_state = (i_q_item.op == OP_SNAP) ? S_S_MIN : S_T_MUL;
                end
            end
            S_T_MUL:   n_state = S_T_ALIGN;
            S_T_ALIGN: n_state = S_T_UPD;
            S_T_UPD: begin
                tick_wr = 1'b1;
                save_en = rolled && r_has[addr];
                n_state = S_IDLE;
            end
            S_S_MIN: begin
                if (r_idx == i_cfg.tracked) begin
                    n_state = S_S_CHECK;
                end else begin
                    if (started && (r_min == '0 || live_start[addr] < r_min)) begin
                        n_min = live_start[addr];
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            S_S_CHECK: begin
                if (r_min == '0 || (r_taken && r_min == r_prior)) begin
                    if (out_free) begin
                        out_wr   = 1'b1;
                        out_data = none_res;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_prior      = r_min;
                    n_taken      = 1'b1;
                    n_idx        = '0;
                    n_pend_valid = 1'b0;
                    n_state      = S_S_WALK;
                end
            end
            S_S_WALK: begin
                if (r_idx == i_cfg.tracked) begin
                    n_state = S_S_END;
                end else if (!entry) begin
                    n_idx = r_idx + 1'b1;
                end else if (!r_pend_valid || out_free) begin
                    // hold one entry back so the final one can carry last
                    out_wr       = r_pend_valid;
                    out_data     = r_pend;
                    n_pend       = new_entry;
                    n_pend_valid = 1'b1;
                    save_en      = aligned;
                    n_idx        = r_idx + 1'b1;
                end
            end
            S_S_END: begin
                if (out_free) begin
                    out_wr = 1'b1;
                    if (r_pend_valid) begin
                        out_data      = r_pend;
                        out_data.last = 1'b1;
                    end else begin
                        out_data = none_res;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // tick datapath: reciprocal multiply, back-multiply, align; pending and result registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
            r_prod <= 64'(i_q_item.tick_time) * 64'(recip);
        end
        r_qp <= 32'(64'(r_prod[63:32]) * 64'(per_len));
        if (r_state == S_T_ALIGN) begin
            r_start <= (i_cfg.period == PERIOD_RAW) ? r_item.tick_time
                                                    : r_item.tick_time - rem1;
        end
        r_pend <= n_pend;
        if (out_wr) begin
            r_out <= out_data;
        end
    end

    // table payload
    always_ff @(posedge i_clk) begin
        if (save_en) begin
            done_open[addr]  <= live_open[addr];
            done_high[addr]  <= live_high[addr];
            done_low[addr]   <= live_low[addr];
            done_close[addr] <= live_close[addr];
            done_vol[addr]   <= live_vol[addr];
        end
        if (tick_wr) begin
            live_open[addr]  <= had ? live_open[addr] : r_item.price;
            live_high[addr]  <= (had && live_high[addr] >= r_item.price)
                                ? live_high[addr] : r_item.price;
            live_low[addr]   <= (had && live_low[addr] <= r_item.price)
                                ? live_low[addr] : r_item.price;
            live_close[addr] <= r_item.price;
            live_vol[addr]   <= vol_sum[VOL_W] ? {VOL_W{1'b1}} : vol_sum[VOL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SYMBOLS; k++) begin
                live_start[k] <= '0;
                live_end[k]   <= '0;
            end
            r_has        <= '0;
            r_done_valid <= '0;
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_min        <= '0;
            r_prior      <= '0;
            r_taken      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (tick_wr) begin
                if (rolled) begin
                    live_start[addr] <= r_start;
                    live_end[addr]   <= end_sum[TIME_W] ? {TIME_W{1'b1}}
                                                        : end_sum[TIME_W-1:0];
                end
                r_has[addr] <= 1'b1;
            end
            if (save_en) begin
                r_done_valid[addr] <= 1'b1;
            end
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_min        <= n_min;
            r_prior      <= n_prior;
            r_taken      <= n_taken;
            r_pend_valid <= n_pend_valid;
            if (out_wr) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

>>> hdl/ohlcv_bar_aggregator.sv
// ----------------------------------------------------------------------------
// ohlcv_bar_aggregator
// Per-symbol OHLCV bars from trade ticks, with snapshot requests.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  input    | i_in_valid / o_in_ready    | operation, symbol, tick_time, price, volume
//  output   | o_out_valid / i_out_ready  | kind, symbol, bar_time, prices, volume, last
//  config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
//  a tick runs through reciprocal multiply, back-multiply, align and table update in turn
//  a snapshot over N tracked slots makes a minimum pass, a check, then an emit pass,
//  one slot per cycle through the single table read port, unless the output stalls
//  ticks for untracked slots are dropped at the input queue
//  reset is synchronous; a full output register stalls the engine wherever it writes
//  a transaction: the none result, the emit pass and the final entry
// ----------------------------------------------------------------------------
`default_nettype none

module ohlcv_bar_aggregator import obar_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [5:0]          i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_operation,
    input  wire logic [4:0]          i_symbol,
    input  wire logic [TIME_W-1:0]   i_tick_time,
    input  wire logic [PRICE_W-1:0]  i_price,
    input  wire logic [VOL_IN_W-1:0] i_trade_volume,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [1:0]               o_kind,
    output logic [4:0]               o_out_symbol,
    output logic [TIME_W-1:0]        o_bar_time,
    output logic [PRICE_W-1:0]       o_open,
    output logic [PRICE_W-1:0]       o_high,
    output logic [PRICE_W-1:0]       o_low,
    output logic [PRICE_W-1:0]       o_close,
    output logic [VOL_W-1:0]         o_bar_volume,
    output logic                     o_last
);

    logic [1:0] r_period;
    logic [5:0] r_symbols;
    t_cfg       cfg;
    t_item      in_item;
    logic       q_valid;
    t_item      q_item;
    logic       q_pop;
    t_result    out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= PERIOD_MIN1;
            r_symbols <= 6'd32;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PERIOD:  r_period  <= i_cfg_data[1:0];
                CFG_SYMBOLS: r_symbols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.period  = r_period;
    assign cfg.tracked = (r_symbols > 6'(NUM_SYMBOLS)) ? CNT_W'(NUM_SYMBOLS)
                                                      : CNT_W'(r_symbols);

    assign in_item.op        = i_operation;
    assign in_item.symbol    = i_symbol;
    assign in_item.tick_time = i_tick_time;
    assign in_item.price     = i_price;
    assign in_item.volume    = i_trade_volume;

    obar_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    obar_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out       (out_res),
        .i_out_ready (i_out_ready)
    );

    assign o_kind       = out_res.kind;
    assign o_out_symbol = out_res.symbol;
    assign o_bar_time   = out_res.bar_time;
    assign o_open       = out_res.open;
    assign o_high       = out_res.high;
    assign o_low        = out_res.low;
    assign o_close      = out_res.close;
    assign o_bar_volume = out_res.volume;
    assign o_last       = out_res.last;

    // a none transaction always closes its snapshot
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_NONE) |-> o_last)
        else $error("none result without last");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_NONE) |->
        (o_bar_time == '0 && o_bar_volume == '0 && o_open == '0 && o_out_symbol == '0))
        else $error("none result with payload");

    // real entries carry the non-zero snapshot minimum
    a_entry_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_NONE) |-> (o_bar_time != '0))
        else $error("entry with zero bar time");

endmodule

`default_nettype wire

>>> tb/ohlcv_bar_aggregator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ohlcv_bar_aggregator_tb
// Drives ticks and snapshot requests into the bar aggregator, keeps its own
// per-symbol bar tables and checks every snapshot entry field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module ohlcv_bar_aggregator_tb;
    import obar_pkg::*;

    localparam int  MAX_CYCLES = 2_000_000;
    localparam int  DRAIN_WAIT = 200;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_index = 1'b0;
    logic [5:0]          i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_operation = 1'b0;
    logic [4:0]          i_symbol = '0;
    logic [TIME_W-1:0]   i_tick_time = '0;
    logic [PRICE_W-1:0]  i_price = '0;
    logic [VOL_IN_W-1:0] i_trade_volume = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [1:0]          o_kind;
    logic [4:0]          o_out_symbol;
    logic [TIME_W-1:0]   o_bar_time;
    logic [PRICE_W-1:0]  o_open, o_high, o_low, o_close;
    logic [VOL_W-1:0]    o_bar_volume;
    logic                o_last;

    ohlcv_bar_aggregator u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [1:0]         cur_period;
    logic [5:0]         cur_symbols;
    logic [TIME_W-1:0]  bar_start [NUM_SYMBOLS];
    logic [TIME_W-1:0]  bar_end   [NUM_SYMBOLS];
    logic [PRICE_W-1:0] bar_open  [NUM_SYMBOLS];
    logic [PRICE_W-1:0] bar_high  [NUM_SYMBOLS];
    logic [PRICE_W-1:0] bar_low   [NUM_SYMBOLS];
    logic [PRICE_W-1:0] bar_close [NUM_SYMBOLS];
    logic [VOL_W-1:0]   bar_vol   [NUM_SYMBOLS];
    logic               bar_live  [NUM_SYMBOLS];
    logic               prev_ok   [NUM_SYMBOLS];
    logic [PRICE_W-1:0] prev_open [NUM_SYMBOLS];
    logic [PRICE_W-1:0] prev_high [NUM_SYMBOLS];
    logic [PRICE_W-1:0] prev_low  [NUM_SYMBOLS];
    logic [PRICE_W-1:0] prev_close[NUM_SYMBOLS];
    logic [VOL_W-1:0]   prev_vol  [NUM_SYMBOLS];
    logic [TIME_W-1:0]  last_snap_time;
    logic               snap_seen;

    t_result expected_entries[$];
    int      errors = 0;
    int      cycles = 0;
    logic    hold_off = 1'b0;
    logic [TIME_W-1:0] base_time;

    function automatic int slots_tracked();
        return (cur_symbols > NUM_SYMBOLS) ? NUM_SYMBOLS : int'(cur_symbols);
    endfunction

    function automatic logic [TIME_W-1:0] bar_length();
        case (cur_period)
            PERIOD_MIN5: return LEN_MIN5;
            PERIOD_DAY:  return LEN_DAY;
            default:     return LEN_MIN1;
        endcase
    endfunction

    task automatic keep_completed(int s);
        prev_ok[s]    = 1'b1;
        prev_open[s]  = bar_open[s];
        prev_high[s]  = bar_high[s];
        prev_low[s]   = bar_low[s];
        prev_close[s] = bar_close[s];
        prev_vol[s]   = bar_vol[s];
    endtask

    task automatic reset_bars();
        cur_period = PERIOD_MIN1;
        cur_symbols = 6'd32;
        last_snap_time = '0;
        snap_seen = 1'b0;
        for (int s = 0; s < NUM_SYMBOLS; s++) begin
            bar_start[s] = '0; bar_end[s] = '0; bar_open[s] = '0;
            bar_high[s] = '0; bar_low[s] = '0; bar_close[s] = '0;
            bar_vol[s] = '0; bar_live[s] = 1'b0; prev_ok[s] = 1'b0;
            prev_open[s] = '0; prev_high[s] = '0; prev_low[s] = '0;
            prev_close[s] = '0; prev_vol[s] = '0;
        end
    endtask

    function automatic t_result none_entry();
        t_result r;
        r = '0;
        r.kind = KIND_NONE;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic apply_tick(int s, logic [TIME_W-1:0] t, logic [PRICE_W-1:0] p,
                              logic [VOL_IN_W-1:0] v);
        logic [TIME_W-1:0] st;
        logic [32:0]       e;
        logic [VOL_W:0]    sum;
        if (s >= slots_tracked()) return;
        st = (cur_period == PERIOD_RAW) ? t : t - (t % bar_length());
        if (st >= bar_end[s]) begin
            e = {1'b0, st} + {1'b0, bar_length()};
            if (bar_live[s]) keep_completed(s);
            bar_start[s] = st;
            bar_end[s] = e[32] ? '1 : e[31:0];
            bar_vol[s] = '0;
            bar_live[s] = 1'b0;
        end
        if (!bar_live[s]) begin
            bar_open[s] = p; bar_high[s] = p; bar_low[s] = p;
        end else begin
            if (p > bar_high[s]) bar_high[s] = p;
            if (p < bar_low[s]) bar_low[s] = p;
        end
        bar_close[s] = p;
        sum = {1'b0, bar_vol[s]} + {17'd0, v};
        bar_vol[s] = sum[VOL_W] ? '1 : sum[VOL_W-1:0];
        bar_live[s] = 1'b1;
    endtask

    task automatic apply_snapshot();
        logic [TIME_W-1:0] m;
        t_result r;
        int k, n;
        m = '0;
        k = 0;
        n = slots_tracked();
        for (int s = 0; s < n; s++)
            if ((bar_live[s] || bar_start[s] != 0) && (m == 0 || bar_start[s] < m))
                m = bar_start[s];
        if (m == 0 || (snap_seen && m == last_snap_time)) begin
            expected_entries.push_back(none_entry());
            return;
        end
        for (int s = 0; s < n; s++) begin
            r = '0;
            r.symbol = s[4:0];
            r.bar_time = m;
            if (bar_live[s] && bar_start[s] == m) begin
                r.kind = KIND_LIVE;
                r.open = bar_open[s]; r.high = bar_high[s]; r.low = bar_low[s];
                r.close = bar_close[s]; r.volume = bar_vol[s];
            end else if (prev_ok[s]) begin
                r.kind = KIND_DONE;
                r.open = prev_open[s]; r.high = prev_high[s]; r.low = prev_low[s];
                r.close = prev_close[s]; r.volume = prev_vol[s];
            end else continue;
            r.last = (k == 0) ? 1'b0 : 1'b0;
            expected_entries.push_back(r);
            k++;
        end
        for (int s = 0; s < n; s++)
            if (bar_live[s] && bar_start[s] == m) keep_completed(s);
        last_snap_time = m;
        snap_seen = 1'b1;
        if (k == 0) expected_entries.push_back(none_entry());
        else begin
            r = expected_entries.pop_back();
            r.last = 1'b1;
            expected_entries.push_back(r);
        end
    endtask

    // sender: bursts with random gaps
    int burst_left = 0;

    // valid is dropped only where the sender idles
    task automatic idle_input();
        i_in_valid <= 1'b0;
    endtask

    task automatic send_item(logic op, logic [4:0] sym, logic [TIME_W-1:0] t,
                             logic [PRICE_W-1:0] p, logic [VOL_IN_W-1:0] v);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) begin
                idle_input();
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_operation <= op; i_symbol <= sym; i_tick_time <= t;
        i_price <= p; i_trade_volume <= v;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_TICK) apply_tick(int'(sym), t, p, v);
        else apply_snapshot();
        @(negedge i_clk);
    endtask

    task automatic tick(logic [4:0] sym, logic [TIME_W-1:0] t, logic [PRICE_W-1:0] p,
                        logic [VOL_IN_W-1:0] v);
        send_item(OP_TICK, sym, t, p, v);
    endtask

    task automatic snapshot();
        send_item(OP_SNAP, 5'($urandom), $urandom, $urandom, $urandom);
    endtask

    task automatic wait_drained();
        idle_input();
        while (expected_entries.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [5:0] val);
        wait_drained();
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PERIOD) cur_period = val[1:0];
        else cur_symbols = val;
    endtask

    // receiver stall pattern, plus a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_off) i_out_ready <= 1'b0;
        else case (cycles / 3000 % 3)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            default: i_out_ready <= (cycles % 7 < 3);
        endcase
    end

    // result checking
    always @(posedge i_clk) begin
        t_result got, want;
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_kind, o_out_symbol, o_bar_time, o_open, o_high, o_low,
                    o_close, o_bar_volume, o_last};
            if (expected_entries.size() == 0) begin
                $display("%0t: unexpected transaction, actual %p", $time, got);
                errors++;
            end else begin
                want = expected_entries.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= MAX_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_directed();
        write_reg(CFG_PERIOD, 6'(PERIOD_MIN1));
        snapshot();                              // nothing started
        tick(5'd0, 32'd1_000_000, 32'd0, 32'd0);
        tick(5'd0, 32'd1_000_010, '1, '1);
        tick(5'd0, 32'd1_000_020, 32'd500, '1);
        tick(5'd1, 32'd1_000_030, 32'd777, 32'd5);
        snapshot();
        snapshot();                              // same minimum again
        tick(5'd0, 32'd1_000_100, 32'd42, 32'd1);
        tick(5'd31, '1, '1, '1);                 // bar end saturates
        tick(5'd31, '1, 32'd1, 32'd1);
        snapshot();
        tick(5'd2, 32'd0, 32'd9, 32'd9);         // start at zero
        snapshot();
        for (int i = 0; i < 5; i++)
            tick(5'd3, 32'd2_000_000, '1, '1);  // large volume accumulation, short of saturation
        write_reg(CFG_PERIOD, 6'(PERIOD_RAW));
        tick(5'd4, 32'd1_234_567, 32'd3, 32'd3);
        tick(5'd4, 32'd1_234_568, 32'd4, 32'd3);
        snapshot();
    endtask

    task automatic test_slot_limits();
        write_reg(CFG_SYMBOLS, 6'd1);
        tick(5'd7, 32'd3_000_000, 32'd1, 32'd1); // untracked, dropped
        tick(5'd0, 32'd3_000_000, 32'd1, 32'd1);
        snapshot();
        write_reg(CFG_SYMBOLS, 6'd0);
        tick(5'd0, 32'd3_100_000, 32'd2, 32'd2);
        snapshot();
        write_reg(CFG_SYMBOLS, 6'd63);
        snapshot();
        write_reg(CFG_SYMBOLS, 6'd32);
    endtask

    task automatic random_phase(int count, logic [1:0] period, logic [5:0] nsym);
        logic [4:0] sym;
        write_reg(CFG_PERIOD, {4'd0, period});
        write_reg(CFG_SYMBOLS, nsym);
        base_time = $urandom_range(1, 32'h7000_0000);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) snapshot();
            else if ($urandom_range(0, 19) == 0)
                tick(5'($urandom), $urandom, $urandom, $urandom);
            else begin
                sym = 5'($urandom_range(0, nsym > 32 ? 31 : nsym - 1));
                base_time += $urandom_range(0, bar_length() / 4);
                tick(sym, base_time, $urandom, $urandom_range(0, 3) == 0 ? $urandom :
                     $urandom_range(0, 1000));
            end
        end
        snapshot();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                for (int i = 0; i < 30; i++) begin
                    base_time += 20;
                    if (i % 5 == 4) snapshot();
                    else tick(5'($urandom_range(0, 7)), base_time, $urandom,
                              $urandom_range(1, 9));
                end
                idle_input();
            end
            begin
                repeat (2000) @(negedge i_clk);
                hold_off = 1'b0;
            end
        join
        wait_drained();
    endtask

    initial begin
        reset_bars();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_slot_limits();
        random_phase(120, PERIOD_MIN1, 6'd8);
        random_phase(120, PERIOD_MIN5, 6'd32);
        random_phase(100, PERIOD_DAY, 6'd3);
        random_phase(60, PERIOD_RAW, 6'd40);
        test_backpressure();
        wait_drained();
        if (errors == 0 && expected_entries.size() == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
